[rtl/ild_pkg.sv]
// Shared types, fault codes and ModR/M sizing for the instruction length decoder.
package ild_pkg;

	localparam int ILD_WINDOW_BYTES = 16;
	localparam int ILD_INPUT_BYTES  = 16;
	localparam int ILD_LOOKAHEAD    = 6;

	localparam logic [1:0] FLT_NONE = 2'd0;
	localparam logic [1:0] FLT_OP   = 2'd1;
	localparam logic [1:0] FLT_WIN  = 2'd2;

	typedef struct packed {
		logic [1:0] fault;
		logic [4:0] len;
	} ild_res_t;

	function automatic ild_res_t res_len(input logic [4:0] l);
		ild_res_t r;
		r.fault = FLT_NONE;
		r.len   = l;
		return r;
	endfunction

	function automatic ild_res_t res_err(input logic [1:0] f);
		ild_res_t r;
		r.fault = f;
		r.len   = 5'd0;
		return r;
	endfunction

	// Size the ModR/M, SIB and displacement; len counts the other bytes (opcode and any immediate).
	function automatic ild_res_t memform(input logic [7:0] m, input logic [7:0] s,
			input logic sok, input logic [4:0] len);
		ild_res_t r;
		logic [4:0] l;
		l = len;
		if (m >= 8'hC0) begin
			r = res_len(l + 5'd1);
		end else if (m[2:0] == 3'd4 && !sok) begin
			r = res_err(FLT_WIN);
		end else if (m[2:0] == 3'd4 && s[2:0] == 3'd5) begin
			r = res_len((m[7:6] == 2'b01) ? l + 5'd3 : l + 5'd6);
		end else begin
			if (m[2:0] == 3'd4) l = l + 5'd1;
			unique case (m[7:6])
				2'b00: r = res_len((m[2:0] == 3'd5) ? l + 5'd5 : l + 5'd1);
				2'b10: r = res_len(l + 5'd5);
				default: r = res_len(l + 5'd2);
			endcase
		end
		return r;
	endfunction

	function automatic logic is_prefix(input logic [7:0] b);
		return b == 8'h64 || b == 8'h65 || b == 8'h36 || b == 8'h66 || b == 8'h67 ||
			b == 8'hF0 || b == 8'hF2 || b == 8'h2E || b == 8'h3E;
	endfunction

endpackage

[rtl/ild_lane.sv]
// One decode lane: length of an instruction whose opcode sits at this lane's byte.
module ild_lane
	import ild_pkg::*;
(
	input  logic [7:0] b [ILD_LOOKAHEAD],
	input  logic [ILD_LOOKAHEAD-1:0] ok,
	output ild_res_t   res,
	output logic       pfx
);

	logic [7:0] op;
	logic [4:0] fl;

	assign op  = b[0];
	assign pfx = is_prefix(op);

	always_comb begin
		res = res_err(FLT_OP);
		fl  = 5'd0;
		if ((op >= 8'h40 && op <= 8'h5F) || (op >= 8'h90 && op <= 8'h99) ||
				(op >= 8'h9C && op <= 8'h9F) || (op >= 8'hA4 && op <= 8'hA8) ||
				(op >= 8'hAA && op <= 8'hAF)) begin
			res = res_len(5'd1);
		end else if ((op >= 8'h70 && op <= 8'h7F) || (op >= 8'hB0 && op <= 8'hB7) ||
				(op >= 8'hE0 && op <= 8'hE3)) begin
			res = res_len(5'd2);
		end else if ((op >= 8'hB8) && (op <= 8'hBF) || (op >= 8'hA0 && op <= 8'hA3)) begin
			res = res_len(5'd5);
		end else if (op < 8'h40 && op[2:0] <= 3'd3) begin
			res = !ok[1] ? res_err(FLT_WIN) : memform(b[1], b[2], ok[2], 5'd1);
		end else if (op < 8'h40 && op[2:0] == 3'd4) begin
			res = res_len(5'd2);
		end else if (op < 8'h40 && op[2:0] == 3'd5) begin
			res = res_len(5'd5);
		end else begin
			unique case (op)
				8'h27, 8'h2F, 8'h37, 8'h3F, 8'h06, 8'hC3, 8'hC9, 8'hCC, 8'hF5, 8'hF8,
				8'hF9, 8'hFC, 8'hFD:
					res = res_len(5'd1);
				8'h6A, 8'hC2, 8'hD8, 8'hEB:
					res = res_len(5'd2);
				8'h68, 8'hA9, 8'hE8:
					res = res_len(5'd5);
				8'hE9:
					res = !ok[5] ? res_err(FLT_WIN) : res_len((b[5] == 8'hCC) ? 5'd6 : 5'd5);
				8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8D, 8'h8F,
				8'hD1, 8'hD2, 8'hD3, 8'hFE, 8'hFF, 8'hDC:
					res = !ok[1] ? res_err(FLT_WIN) : memform(b[1], b[2], ok[2], 5'd1);
				8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6, 8'h6B:
					res = !ok[1] ? res_err(FLT_WIN) : memform(b[1], b[2], ok[2], 5'd2);
				8'h81, 8'hC7, 8'h69:
					res = !ok[1] ? res_err(FLT_WIN) : memform(b[1], b[2], ok[2], 5'd5);
				8'h9B: begin
					if (!ok[1]) res = res_err(FLT_WIN);
					else if (b[1] != 8'hDF) res = res_err(FLT_OP);
					else if (!ok[2]) res = res_err(FLT_WIN);
					else res = (b[2] == 8'hE0) ? res_len(5'd3) : res_err(FLT_OP);
				end
				8'hD9: begin
					if (!ok[1]) res = res_err(FLT_WIN);
					else if (b[1] == 8'hC9 || b[1] == 8'hD0 || b[1] == 8'hE0 ||
							b[1] == 8'hE1 || b[1] == 8'hE4 || b[1] == 8'hE5 ||
							(b[1] >= 8'hE8 && b[1] <= 8'hEE) || b[1] >= 8'hF8 ||
							b[1][5:3] == 3'd1)
						res = res_len(5'd2);
					else res = memform(b[1], b[2], ok[2], 5'd1);
				end
				8'hDB: begin
					if (!ok[1]) res = res_err(FLT_WIN);
					else if (b[1] == 8'hE3 || b[1][5:3] == 3'd1) res = res_len(5'd2);
					else res = memform(b[1], b[2], ok[2], 5'd1);
				end
				8'hDD: begin
					if (!ok[1]) res = res_err(FLT_WIN);
					else if (b[1] == 8'hE1 || b[1] == 8'hE9) res = res_len(5'd2);
					else if (b[1][5:3] == 3'd1) res = res_err(FLT_OP);
					else if (b[1][5:3] == 3'd4 || b[1][5:3] == 3'd5) res = res_len(5'd2);
					else res = memform(b[1], b[2], ok[2], 5'd1);
				end
				8'hF3: begin
					if (!ok[1]) res = res_err(FLT_WIN);
					else begin
						unique case (b[1])
							8'h90, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hAA, 8'hAB:
								res = res_len(5'd2);
							8'hC3: begin
								if (!ok[2]) res = res_err(FLT_WIN);
								else if (b[2] != 8'hCC) res = res_len(5'd2);
								else if (!ok[3]) res = res_err(FLT_WIN);
								else if (b[3] != 8'hCC) res = res_err(FLT_OP);
								else if (!ok[4]) res = res_err(FLT_WIN);
								else res = (b[4] == 8'hCC) ? res_len(5'd5) : res_err(FLT_OP);
							end
							8'h66: begin
								if (!ok[2]) res = res_err(FLT_WIN);
								else res = (b[2] == 8'hA5) ? res_len(5'd3) : res_err(FLT_OP);
							end
							8'h0F: begin
								if (!ok[2]) res = res_err(FLT_WIN);
								else if (b[2] == 8'hE6 || b[2] == 8'h10 || b[2] == 8'h11 ||
										b[2] == 8'h58 || b[2] == 8'h5C)
									res = !ok[3] ? res_err(FLT_WIN) :
										memform(b[3], b[4], ok[4], 5'd3);
								else res = res_err(FLT_OP);
							end
							default: res = res_err(FLT_OP);
						endcase
					end
				end
				8'hF6, 8'hF7: begin
					if (!ok[1]) res = res_err(FLT_WIN);
					else begin
						// opcode byte, then the immediate; memform adds the ModR/M byte
						fl = 5'd1;
						if (b[1][5:4] == 2'b00) fl = fl + ((op == 8'hF6) ? 5'd1 : 5'd4);
						res = memform(b[1], b[2], ok[2], fl);
					end
				end
				8'h0F: begin
					if (!ok[1]) res = res_err(FLT_WIN);
					else if ((b[1] >= 8'h40 && b[1] <= 8'h4F) ||
							(b[1] >= 8'h90 && b[1] <= 8'h9F))
						res = !ok[2] ? res_err(FLT_WIN) : memform(b[2], b[3], ok[3], 5'd2);
					else if (b[1] >= 8'h80 && b[1] <= 8'h8F)
						res = res_len(5'd6);
					else begin
						unique case (b[1])
							8'h31, 8'hA2: res = res_len(5'd2);
							8'hAE: begin
								if (!ok[2]) res = res_err(FLT_WIN);
								else res = (b[2] == 8'hE8 || b[2] == 8'hF0 || b[2] == 8'hF8) ?
									res_len(5'd3) : res_err(FLT_OP);
							end
							8'hB1, 8'hB6, 8'hB7, 8'hBC, 8'hBD, 8'hC1, 8'hC7, 8'h57, 8'h11,
							8'h2A, 8'h10, 8'h1F, 8'hBE, 8'h6E, 8'h2C, 8'h2E, 8'h2F, 8'h5C,
							8'h58, 8'h59:
								res = !ok[2] ? res_err(FLT_WIN) :
									memform(b[2], b[3], ok[3], 5'd2);
							default: res = res_err(FLT_OP);
						endcase
					end
				end
				default: res = res_err(FLT_OP);
			endcase
		end
	end

endmodule

[rtl/ild_merge.sv]
// Merge: pick the lane at the end of the prefix run and add the prefix count.
module ild_merge
	import ild_pkg::*;
#(
	parameter int WINDOW_BYTES = ILD_WINDOW_BYTES
) (
	input  ild_res_t   lane_res [WINDOW_BYTES],
	input  logic [WINDOW_BYTES-1:0] lane_pfx,
	output logic [4:0] length,
	output logic [1:0] fault
);

	localparam int TW = 7;

	logic            found;
	ild_res_t        sel;
	logic [TW-1:0]   total;

	always_comb begin
		found = 1'b0;
		sel   = res_err(FLT_WIN);
		total = '0;
		for (int k = 0; k < WINDOW_BYTES; k++) begin
			if (!found && !lane_pfx[k]) begin
				found = 1'b1;
				sel   = lane_res[k];
				total = TW'(k) + TW'(lane_res[k].len);
			end
		end
		if (sel.fault != FLT_NONE) begin
			fault  = sel.fault;
			length = 5'd0;
		end else if (total > TW'(WINDOW_BYTES) || total > TW'(31)) begin
			fault  = FLT_WIN;
			length = 5'd0;
		end else begin
			fault  = FLT_NONE;
			length = total[4:0];
		end
	end

endmodule

[rtl/x86_instruction_length_decoder.sv]
// x86 instruction length decoder top level: lane array, merge and output register.
// An accepted input beat reaches the output through the lane register, then the output register.
// Throughput: one beat per cycle unless m_tready stalls; every lane decodes its own byte at once.
// First stage: one lane's opcode decode plus ModR/M sizing; second: prefix-run select and add.
// Reset (arst_n low, asynchronous) empties both pipeline stages; the block is stateless otherwise.
module x86_instruction_length_decoder
	import ild_pkg::*;
#(
	parameter int WINDOW_BYTES = ILD_WINDOW_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // code_low [63:0], code_high [127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata    // length [4:0], fault [6:5], zero [7]
);

	localparam int EXT = WINDOW_BYTES + ILD_LOOKAHEAD;

	// Window bytes with lookahead; bytes past the input read as zero,
	// bytes past the window are flagged as not available.
	logic [7:0] wb  [EXT];
	logic       wok [EXT];

	always_comb begin
		for (int k = 0; k < EXT; k++) begin
			wb[k]  = (k < ILD_INPUT_BYTES) ? s_tdata[8*k +: 8] : 8'h00;
			wok[k] = (k < WINDOW_BYTES);
		end
	end

	ild_res_t                lane_res [WINDOW_BYTES];
	logic [WINDOW_BYTES-1:0] lane_pfx;

	for (genvar p = 0; p < WINDOW_BYTES; p++) begin : g_lane
		logic [7:0]               lb  [ILD_LOOKAHEAD];
		logic [ILD_LOOKAHEAD-1:0] lok;
		for (genvar j = 0; j < ILD_LOOKAHEAD; j++) begin : g_tap
			assign lb[j]  = wb[p+j];
			assign lok[j] = wok[p+j];
		end
		ild_lane u_lane (
			.b   (lb),
			.ok  (lok),
			.res (lane_res[p]),
			.pfx (lane_pfx[p])
		);
	end

	// Lane register stage.
	ild_res_t                res_s1 [WINDOW_BYTES];
	logic [WINDOW_BYTES-1:0] pfx_s1;
	logic                    valid_s1;
	logic                    advance;

	// Advance the output when it is empty or being taken; the lane stage
	// may still fill while the output holds.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			res_s1 <= lane_res;
			pfx_s1 <= lane_pfx;
		end
	end

	logic [4:0] mlen;
	logic [1:0] mflt;

	ild_merge #(.WINDOW_BYTES(WINDOW_BYTES)) u_merge (
		.lane_res (res_s1),
		.lane_pfx (pfx_s1),
		.length   (mlen),
		.fault    (mflt)
	);

	// Output register.
	logic       out_valid_q;
	logic [4:0] len_q;
	logic [1:0] flt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			len_q <= mlen;
			flt_q <= mflt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, flt_q, len_q};

`ifndef ASSERT_OFF
	a_fault_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:5] != FLT_NONE |-> m_tdata[4:0] == 5'd0)
		else $error("nonzero length with fault");
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:5] != 2'd3)
		else $error("invalid fault code");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
	a_fill_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> m_tvalid)
		else $error("lane stage result lost");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking bench for the x86 instruction length decoder stream block.
module tb_top;
	import ild_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = ILD_WINDOW_BYTES;
	localparam int N_RANDOM = 1300;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // code_low [63:0], code_high [127:64]
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;   // length [4:0], fault [6:5], zero [7]

	x86_instruction_length_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct packed {
		logic [1:0] fault;
		logic [4:0] len;
	} length_t;

	// Directed row: code bytes plus an optional typed-in answer.
	typedef struct {
		logic [127:0] code;
		bit           known;
		length_t      answer;
	} row_t;

	length_t expected_lengths[$];
	int      errors;
	int      idle_pct, stall_pct;
	bit      hold_off;
	bit      done_sending;

	// ---------------------------------------------------------------
	// Length predictor: decode order mirrors the hardware spec.
	// Negative returns: -1 unhandled opcode, -2 byte beyond window.
	// ---------------------------------------------------------------
	logic [7:0] code_bytes[32];

	function automatic int get_byte(int i);
		if (i >= WIN || i >= 32) return -2;
		return code_bytes[i];
	endfunction

	function automatic int size_mem(int m, int nxt, int n);
		int s;
		if (m >= 'hC0) return n + 1;
		if ((m & 7) == 4) begin
			n++;
			s = get_byte(nxt);
			if (s < 0) return -2;
			if ((s & 7) == 5) return ((m & 'hC0) == 'h40) ? n + 2 : n + 5;
		end
		case (m & 'hC0)
			'h00: return ((m & 7) == 5) ? n + 5 : n + 1;
			'h80: return n + 5;
			default: return n + 2;
		endcase
	endfunction

	function automatic int size_modrm(int at, int n);
		int m;
		m = get_byte(at);
		if (m < 0) return -2;
		return size_mem(m, at + 1, n);
	endfunction

	function automatic bit prefix_byte(int b);
		return b == 'h64 || b == 'h65 || b == 'h36 || b == 'h66 || b == 'h67 ||
			b == 'hF0 || b == 'hF2 || b == 'h2E || b == 'h3E;
	endfunction

	function automatic int two_byte_len(int i, int n);
		int b, c;
		b = get_byte(i);
		n += 2;
		if (b < 0) return -2;
		if ((b >= 'h40 && b <= 'h4F) || (b >= 'h90 && b <= 'h9F)) return size_modrm(i + 1, n);
		if (b >= 'h80 && b <= 'h8F) return n + 4;
		case (b)
			'h31, 'hA2: return n;
			'hAE: begin
				c = get_byte(i + 1);
				if (c < 0) return -2;
				return (c == 'hE8 || c == 'hF0 || c == 'hF8) ? n + 1 : -1;
			end
			'hB1, 'hB6, 'hB7, 'hBC, 'hBD, 'hC1, 'hC7, 'h57, 'h11, 'h2A, 'h10, 'h1F,
			'hBE, 'h6E, 'h2C, 'h2E, 'h2F, 'h5C, 'h58, 'h59:
				return size_modrm(i + 1, n);
			default: return -1;
		endcase
	endfunction

	function automatic int rep_len(int i, int n);
		int b, c;
		b = get_byte(i);
		if (b < 0) return -2;
		case (b)
			'h90, 'hA4, 'hA5, 'hA6, 'hA7, 'hAA, 'hAB: return n + 2;
			'hC3: begin
				c = get_byte(i + 1);
				if (c < 0) return -2;
				if (c != 'hCC) return n + 2;
				c = get_byte(i + 2);
				if (c < 0) return -2;
				if (c != 'hCC) return -1;
				c = get_byte(i + 3);
				if (c < 0) return -2;
				return (c == 'hCC) ? n + 5 : -1;
			end
			'h66: begin
				c = get_byte(i + 1);
				if (c < 0) return -2;
				return (c == 'hA5) ? n + 3 : -1;
			end
			'h0F: begin
				c = get_byte(i + 1);
				if (c < 0) return -2;
				if (c == 'hE6 || c == 'h10 || c == 'h11 || c == 'h58 || c == 'h5C)
					return size_modrm(i + 2, n + 3);
				return -1;
			end
			default: return -1;
		endcase
	endfunction

	function automatic int fpu_len(int op, int i, int n);
		int m, r;
		m = get_byte(i);
		if (m < 0) return -2;
		r = (m >> 3) & 7;
		if (op == 'hD9) begin
			if (m == 'hC9 || m == 'hD0 || m == 'hE0 || m == 'hE1 || m == 'hE4 ||
				m == 'hE5 || (m >= 'hE8 && m <= 'hEE) || m >= 'hF8) return n + 1;
			if (r == 1) return n + 1;
		end else if (op == 'hDB) begin
			if (m == 'hE3 || r == 1) return n + 1;
		end else begin
			if (m == 'hE1 || m == 'hE9) return n + 1;
			if (r == 1) return -1;
			if (r == 4 || r == 5) return n + 1;
		end
		return size_mem(m, i + 1, n);
	endfunction

	function automatic int raw_len();
		int i, n, op, b, m;
		i = 0;
		n = 0;
		forever begin
			op = get_byte(i);
			if (op < 0) return -2;
			if (!prefix_byte(op)) break;
			n++;
			i++;
		end
		i++;
		if ((op >= 'h40 && op <= 'h5F) || (op >= 'h90 && op <= 'h99) ||
			(op >= 'h9C && op <= 'h9F) || (op >= 'hA4 && op <= 'hA8) ||
			(op >= 'hAA && op <= 'hAF)) return n + 1;
		if ((op >= 'h70 && op <= 'h7F) || (op >= 'hB0 && op <= 'hB7) ||
			(op >= 'hE0 && op <= 'hE3)) return n + 2;
		if ((op >= 'hB8 && op <= 'hBF) || (op >= 'hA0 && op <= 'hA3)) return n + 5;
		if (op < 'h40 && (op & 7) <= 3) return size_modrm(i, n + 1);
		if (op < 'h40 && (op & 7) == 4) return n + 2;
		if (op < 'h40 && (op & 7) == 5) return n + 5;
		case (op)
			'h27, 'h2F, 'h37, 'h3F, 'h06, 'hC3, 'hC9, 'hCC, 'hF5, 'hF8, 'hF9, 'hFC, 'hFD:
				return n + 1;
			'h6A, 'hC2, 'hD8, 'hEB: return n + 2;
			'h68, 'hA9, 'hE8: return n + 5;
			'hE9: begin
				b = get_byte(i + 4);
				if (b < 0) return -2;
				return (b == 'hCC) ? n + 6 : n + 5;
			end
			'h84, 'h85, 'h86, 'h87, 'h88, 'h89, 'h8A, 'h8B, 'h8D, 'h8F, 'hD1, 'hD2,
			'hD3, 'hFE, 'hFF, 'hDC:
				return size_modrm(i, n + 1);
			'h80, 'h82, 'h83, 'hC0, 'hC1, 'hC6, 'h6B: return size_modrm(i, n + 2);
			'h81, 'hC7, 'h69: return size_modrm(i, n + 5);
			'h9B: begin
				b = get_byte(i);
				if (b < 0) return -2;
				if (b != 'hDF) return -1;
				b = get_byte(i + 1);
				if (b < 0) return -2;
				return (b == 'hE0) ? n + 3 : -1;
			end
			'hD9, 'hDB, 'hDD: return fpu_len(op, i, n + 1);
			'hF3: return rep_len(i, n);
			'hF6, 'hF7: begin
				m = get_byte(i);
				if (m < 0) return -2;
				n++;
				if ((m & 'h30) == 0) n += (op == 'hF6) ? 1 : 4;
				return size_mem(m, i + 1, n);
			end
			'h0F: return two_byte_len(i, n);
			default: return -1;
		endcase
	endfunction

	function automatic length_t predict_length(logic [127:0] code);
		int r;
		length_t res;
		for (int k = 0; k < 32; k++) code_bytes[k] = (k < 16) ? code[8*k +: 8] : 8'h00;
		r = raw_len();
		if (r > 0 && (r > WIN || r > 31)) r = -2;
		if (r == -1) res = '{fault: FLT_OP, len: 5'd0};
		else if (r < 0) res = '{fault: FLT_WIN, len: 5'd0};
		else res = '{fault: FLT_NONE, len: r[4:0]};
		return res;
	endfunction

	// Place a byte sequence at the front of a given window.
	function automatic logic [127:0] front(input logic [127:0] tail, input int nb,
			input logic [127:0] head);
		logic [127:0] w;
		w = tail;
		for (int k = 0; k < nb; k++) w[8*k +: 8] = head[8*k +: 8];
		return w;
	endfunction

	function automatic logic [127:0] rand_window();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Mostly well-formed instruction start: prefixes, a known opcode, random body.
	function automatic logic [127:0] rand_instruction();
		logic [7:0] pfx[9] = '{8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'h66, 8'h67, 8'hF0, 8'hF2};
		logic [7:0] ops[] = '{8'h00, 8'h01, 8'h03, 8'h04, 8'h05, 8'h50, 8'h74, 8'hB8,
			8'hA1, 8'h27, 8'h6A, 8'h68, 8'hE9, 8'h8B, 8'h80, 8'h81, 8'h9B, 8'hD9,
			8'hDB, 8'hDD, 8'hF3, 8'hF6, 8'hF7, 8'h0F, 8'hC3, 8'hFF, 8'h69, 8'hC7};
		logic [7:0] esc0f[] = '{8'h44, 8'h94, 8'h84, 8'h31, 8'hA2, 8'hAE, 8'hB6, 8'hAF,
			8'hB0, 8'h1F, 8'h59, 8'hFF};
		logic [7:0] escf3[] = '{8'h90, 8'hA5, 8'hAB, 8'hC3, 8'h66, 8'h0F, 8'h12};
		logic [127:0] w;
		int np, p;
		w = rand_window();
		np = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(0, 2);
		for (p = 0; p < np; p++) w[8*p +: 8] = pfx[$urandom_range(0, 8)];
		if (p < 16) begin
			w[8*p +: 8] = ops[$urandom_range(0, ops.size() - 1)];
			if (p + 1 < 16) begin
				case (w[8*p +: 8])
					8'h0F: w[8*(p+1) +: 8] = esc0f[$urandom_range(0, esc0f.size() - 1)];
					8'hF3: w[8*(p+1) +: 8] = escf3[$urandom_range(0, escf3.size() - 1)];
					8'h9B: if ($urandom_range(0, 3) != 0) w[8*(p+1) +: 8] = 8'hDF;
					default: ;
				endcase
			end
			// bias toward the CC runs used by the jump peek and F3 C3 forms
			if ($urandom_range(0, 3) == 0)
				for (int k = p + 2; k < p + 6 && k < 16; k++) w[8*k +: 8] = 8'hCC;
			if (p + 2 < 16 && $urandom_range(0, 3) == 0)
				w[8*(p+2) +: 8] = {w[8*(p+2)+6 +: 2], 3'($urandom), 3'd5};
			if (p + 2 < 16 && w[8*p +: 8] == 8'h9B && $urandom_range(0, 1))
				w[8*(p+2) +: 8] = 8'hE0;
		end
		return w;
	endfunction

	// ---------------------------------------------------------------
	// Clock and limit
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Timeout at %0t", $realtime);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// Receiver: random stall, or a long hold-off when asked.
	// ---------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Check every output beat against the oldest prediction.
	always @(posedge clk) begin
		length_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[6:0];
			if (expected_lengths.size() == 0) begin
				$display("%0t: unexpected beat, actual fault=%0d length=%0d",
					$realtime, got.fault, got.len);
				errors++;
			end else begin
				want = expected_lengths.pop_front();
				if (got.fault !== want.fault)
					$display("%0t: fault mismatch, expected %0d actual %0d",
						$realtime, want.fault, got.fault);
				if (got.len !== want.len)
					$display("%0t: length mismatch, expected %0d actual %0d",
						$realtime, want.len, got.len);
				if (got !== want || m_tdata[7] !== 1'b0) errors++;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------
	task automatic send_window(input logic [127:0] code);
		s_tdata  <= code;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_lengths.push_back(predict_length(code));
		@(negedge clk);
		// idle between beats; keep tvalid high when no gap is taken
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (expected_lengths.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	initial begin
		row_t rows[$];
		length_t want;
		int phase;
		errors       = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_off     = 1'b0;
		done_sending = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows: hex literals list the highest byte first, byte 0 last
		rows.push_back('{128'h0, 1'b1, '{FLT_NONE, 5'd2}});              // add [eax],al
		rows.push_back('{{128{1'b1}}, 1'b1, '{FLT_OP, 5'd0}});           // FF FF: ok? predictor
		rows[$].known = 1'b0;
		rows.push_back('{{16{8'h66}}, 1'b1, '{FLT_WIN, 5'd0}});          // prefixes fill window
		rows.push_back('{front(128'h0, 1, 128'h90), 1'b1, '{FLT_NONE, 5'd1}});
		rows.push_back('{front(128'h0, 1, 128'hC3), 1'b1, '{FLT_NONE, 5'd1}});
		rows.push_back('{front(128'h0, 1, 128'h62), 1'b1, '{FLT_OP, 5'd0}});  // unknown
		rows.push_back('{front(128'h0, 6, 48'hCC_00000000_E9), 1'b1, '{FLT_NONE, 5'd6}});
		rows.push_back('{front(128'h0, 6, 48'h90_00000000_E9), 1'b1, '{FLT_NONE, 5'd5}});
		rows.push_back('{front(128'h0, 5, 40'hCC_CC_CC_C3_F3), 1'b1, '{FLT_NONE, 5'd5}});
		rows.push_back('{front(128'h0, 5, 40'h90_CC_CC_C3_F3), 1'b1, '{FLT_OP, 5'd0}});
		rows.push_back('{front(128'h0, 2, 16'hA2_0F), 1'b1, '{FLT_NONE, 5'd2}});  // CPUID
		rows.push_back('{front(128'h0, 2, 16'hAF_0F), 1'b1, '{FLT_OP, 5'd0}});
		rows.push_back('{front(128'h0, 2, 16'hB0_0F), 1'b1, '{FLT_OP, 5'd0}});
		rows.push_back('{front(128'h0, 2, 16'hC0_F6), 1'b1, '{FLT_NONE, 5'd3}});  // test al,imm8
		rows.push_back('{front(128'h0, 2, 16'hC0_F7), 1'b1, '{FLT_NONE, 5'd6}});
		rows.push_back('{front(128'h0, 2, 16'hD0_F7), 1'b1, '{FLT_NONE, 5'd2}});  // not
		rows.push_back('{front(128'h0, 3, 24'hE0_DF_9B), 1'b1, '{FLT_NONE, 5'd3}});
		rows.push_back('{front(128'h0, 2, 16'h08_DD), 1'b1, '{FLT_OP, 5'd0}});
		rows.push_back('{front(128'h0, 3, 24'h24_84_8B), 1'b0, '{FLT_NONE, 5'd0}});
		rows.push_back('{front(128'h0, 3, 24'hE8_AE_0F), 1'b0, '{FLT_NONE, 5'd0}});
		rows.push_back('{front(128'h0, 2, 16'hC9_D9), 1'b1, '{FLT_NONE, 5'd2}});
		rows.push_back('{{8'h81, {15{8'h66}}}, 1'b1, '{FLT_WIN, 5'd0}}); // ops fits? predictor
		rows[$].known = 1'b0;
		rows.push_back('{{8'h05, {15{8'h2E}}}, 1'b1, '{FLT_WIN, 5'd0}});   // overruns window
		rows.push_back('{front(128'h0, 3, 24'h00_A5_66), 1'b0, '{FLT_NONE, 5'd0}});
		foreach (rows[r]) begin
			want = predict_length(rows[r].code);
			if (rows[r].known && want !== rows[r].answer) begin
				$display("%0t: table row %0d, expected fault=%0d length=%0d actual %0d/%0d",
					$realtime, r, rows[r].answer.fault, rows[r].answer.len,
					want.fault, want.len);
				errors++;
			end
			send_window(rows[r].code);
		end
		s_tvalid <= 1'b0;
		drain();

		// long receiver hold-off while the sender keeps pushing
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (30) send_window(rand_instruction());
		join
		s_tvalid <= 1'b0;
		drain();

		for (phase = 0; phase < 4; phase++) begin
			idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 33 : 47) : 0;
			stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 33 : 47) : 0;
			repeat (N_RANDOM / 4)
				send_window(($urandom_range(0, 4) == 0) ? rand_window() : rand_instruction());
		end
		s_tvalid <= 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		drain();

		if (errors == 0 && expected_lengths.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
